// ===== src/assert_macros.svh =====
// assertion macros for the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked every clock outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== src/fpcm_pkg.sv =====
// types and constants for the float to pcm sample packer
// no dependencies
package fpcm_pkg;
    typedef enum logic [2:0] {
        FMT_U8  = 3'd0,
        FMT_S8  = 3'd1,
        FMT_S16 = 3'd2,
        FMT_S24 = 3'd3,
        FMT_S32 = 3'd4,
        FMT_F32 = 3'd5,
        FMT_F64 = 3'd6,
        FMT_RSV = 3'd7
    } t_fmt;

    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_ENDIAN = 1'b1;

    typedef struct packed {
        t_fmt fmt;
        logic big;
    } t_cfg;

    // stage 1 -> stage 2: decoded operand
    typedef struct packed {
        t_cfg        cfg;
        logic [63:0] bits;
        logic        sign;
        logic        is_nan;
        logic        sat;      // magnitude at or above the clip bound
        logic [52:0] sig;
        logic [5:0]  shr;      // right shift of sig to integer+2 fraction bits
        logic        zero;     // magnitude below a quarter lsb scale
    } t_dec;

    // stage 2 -> stage 3
    typedef struct packed {
        t_cfg        cfg;
        logic [63:0] word;
    } t_wrd;

    function automatic logic [3:0] fmt_bytes(t_fmt f);
        logic [3:0] n;
        case (f)
            FMT_U8, FMT_S8: n = 4'd1;
            FMT_S16:        n = 4'd2;
            FMT_S24:        n = 4'd3;
            FMT_S32, FMT_F32: n = 4'd4;
            default:        n = 4'd8;
        endcase
        return n;
    endfunction
endpackage

// ===== src/fpcm_if.sv =====
// valid/ready channel carrying a payload
// depends on nothing
interface fpcm_if #(parameter int W = 64) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/fpcm_cfg_if.sv =====
// configuration write channel
// depends on nothing
interface fpcm_cfg_if (input logic i_clk);
    logic        valid;
    logic        ready;
    logic        index;
    logic [63:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== src/fpcm_decode.sv =====
// stage 1: unpack the double, compute shift and saturation
// depends on fpcm_pkg
module fpcm_decode (
    input  fpcm_pkg::t_cfg i_cfg,
    input  logic [63:0]    i_bits,
    output fpcm_pkg::t_dec o_dec
);
    import fpcm_pkg::*;
    logic [10:0] exp;
    logic [5:0]  nb;
    logic [12:0] sh;
    always_comb begin
        exp = i_bits[62:52];
        case (i_cfg.fmt)
            FMT_U8, FMT_S8: nb = 6'd7;
            FMT_S16:        nb = 6'd15;
            FMT_S24:        nb = 6'd23;
            default:        nb = 6'd31;
        endcase
        // value*2^nb; magnitude >= 2^nb saturates
        o_dec.cfg    = i_cfg;
        o_dec.bits   = i_bits;
        o_dec.sign   = i_bits[63];
        o_dec.is_nan = (exp == 11'h7FF) && (i_bits[51:0] != 52'd0);
        o_dec.sat    = exp >= 11'd1023;
        o_dec.sig    = {exp != 11'd0, i_bits[51:0]};
        // fixed point with 2 fraction bits: shift = 1075 - 2 - nb - exp
        sh           = 13'd1073 - 13'(nb) - 13'(exp);
        o_dec.zero   = exp < (11'd1021 - 11'(nb));
        o_dec.shr    = (sh > 13'd63) ? 6'd63 : sh[5:0];
    end
endmodule

// ===== src/fpcm_convert.sv =====
// stage 2: rounding and saturation to the pcm word, or float32/float64 output
// depends on fpcm_pkg
module fpcm_convert (
    input  fpcm_pkg::t_dec i_dec,
    output fpcm_pkg::t_wrd o_wrd
);
    import fpcm_pkg::*;
    logic [52:0] fx;      // magnitude*2^nb with 2 fraction bits
    logic [32:0] mag;
    logic [32:0] maxp;
    logic [32:0] sval;
    logic [5:0]  nb;
    logic [31:0] f32;
    logic [10:0] e;
    logic [11:0] fe;
    logic [52:0] sig;
    logic [28:0] rem;
    logic [31:0] r;
    logic [6:0]  s;
    logic [52:0] q;
    logic [53:0] msk;
    logic [52:0] rm;
    logic [52:0] hf;
    logic [8:0]  u;
    logic [54:0] ux;      // magnitude*128 with 48 fraction bits
    logic [47:0] ut;
    logic [6:0]  um;
    logic        ust;
    logic [5:0]  ush;
    logic        rup;
    always_comb begin
        case (i_dec.cfg.fmt)
            FMT_U8, FMT_S8: nb = 6'd7;
            FMT_S16:        nb = 6'd15;
            FMT_S24:        nb = 6'd23;
            default:        nb = 6'd31;
        endcase
        fx   = i_dec.zero ? 53'd0 : (i_dec.sig >> i_dec.shr);
        mag  = 33'(fx[52:2]) + 33'(fx[1]);
        maxp = 33'd1 << nb;
        if (i_dec.sat || mag >= maxp)
            mag = i_dec.sign ? maxp : maxp - 33'd1;
        sval = i_dec.sign ? (33'd0 - mag) : mag;
        if (i_dec.is_nan)
            sval = 33'd0;
        // float32
        e   = i_dec.bits[62:52];
        sig = {1'b1, i_dec.bits[51:0]};
        fe  = 12'(e) - 12'd896;
        rem = sig[28:0];
        r   = {1'b0, fe[7:0] - 8'd1, 23'd0} + {8'd0, sig[52:29]};
        if (rem > 29'h10000000 || (rem == 29'h10000000 && sig[29]))
            r = r + 32'd1;
        s   = 7'd30 - fe[6:0];
        msk = (54'd1 << s) - 54'd1;
        q   = sig >> s;
        rm  = sig & msk[52:0];
        hf  = 53'd1 << (s - 7'd1);
        if (rm > hf || (rm == hf && q[0]))
            q = q + 53'd1;
        if (e == 11'h7FF)
            f32 = {i_dec.sign, 8'hFF, (i_dec.bits[51:0] != 52'd0),
                   i_dec.bits[50:29] | {22{1'b0}}};
        else if (e == 11'd0 || e < 11'd873)
            f32 = {i_dec.sign, 31'd0};
        else if (e >= 11'd1151)
            f32 = {i_dec.sign, 31'h7F800000};
        else if (e >= 11'd897)
            f32 = {i_dec.sign, (r >= 32'h7F800000) ? 31'h7F800000 : r[30:0]};
        else
            f32 = {i_dec.sign, q[30:0]};
        // u8: ties follow the double rounding of v*128+128 before round half up
        ush = (e < 11'd957) ? 6'd63 : 6'(11'd1020 - e);
        if (e >= 11'd1020) begin
            ux  = {2'b00, i_dec.sig} << e[1:0];
            ust = 1'b0;
        end else begin
            ux  = {2'b00, i_dec.sig} >> ush;
            ust = ({2'b00, i_dec.sig} & ((55'd1 << ush) - 55'd1)) != 55'd0;
        end
        um = ux[54:48];
        ut = ux[47:0];
        if (!i_dec.sign) begin
            rup = ut >= 48'h7FFF_FFFF_FFFC;
            u   = 9'd128 + {2'b00, um} + {8'd0, rup};
        end else begin
            if (e >= 11'd1022)
                rup = ut <= 48'h8000_0000_0000;
            else
                rup = (ut < 48'h8000_0000_0002) || (ut == 48'h8000_0000_0002 && !ust);
            u   = 9'd127 - {2'b00, um} + {8'd0, rup};
        end
        if (u > 9'd255)
            u = 9'd255;
        if (i_dec.sat)
            u = i_dec.sign ? 9'd0 : 9'd255;
        if (i_dec.is_nan)
            u = 9'd0;
        o_wrd.cfg = i_dec.cfg;
        case (i_dec.cfg.fmt)
            FMT_U8:  o_wrd.word = {56'd0, u[7:0]};
            FMT_S8:  o_wrd.word = {56'd0, sval[7:0]};
            FMT_S16: o_wrd.word = {48'd0, sval[15:0]};
            FMT_S24: o_wrd.word = {40'd0, sval[23:0]};
            FMT_S32: o_wrd.word = {32'd0, sval[31:0]};
            FMT_F32: o_wrd.word = {32'd0, f32};
            default: o_wrd.word = i_dec.bits;
        endcase
    end
endmodule

// ===== src/fpcm_pack.sv =====
// stage 3: byte ordering and count
// depends on fpcm_pkg
module fpcm_pack (
    input  fpcm_pkg::t_wrd i_wrd,
    output logic [63:0]    o_bytes,
    output logic [3:0]     o_count
);
    import fpcm_pkg::*;
    logic [3:0] n;
    always_comb begin
        n = fmt_bytes(i_wrd.cfg.fmt);
        o_bytes = i_wrd.word;
        if (i_wrd.cfg.big) begin
            o_bytes = 64'd0;
            for (int i = 0; i < 8; i++) begin
                if (4'(i) < n)
                    o_bytes[8*i +: 8] = i_wrd.word[8*(3'(n - 4'd1 - 4'(i))) +: 8];
            end
        end
        o_count = n;
    end
endmodule

// ===== src/float_to_pcm_sample_packer.sv =====
// float to pcm sample packer, three register stages plus output register
// result registered in r_dec, r_wrd, r_w3, r_out; one word per cycle unless stalled
// a stall holds full stages; a stage loads when it is empty or the next moves
// reset clears valid bits and sets format s16, little endian
// depends on fpcm_pkg, fpcm_if, fpcm_cfg_if, fpcm_decode, fpcm_convert, fpcm_pack
`include "assert_macros.svh"
module float_to_pcm_sample_packer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fpcm_cfg_if.sink   i_cfg,
    fpcm_if.sink       i_in,
    fpcm_if.source     o_out,
    output logic [3:0] o_byte_count
);
    import fpcm_pkg::*;
    t_cfg        r_cfg;
    logic [3:0]  r_v;
    t_dec        r_dec, n_dec;
    t_wrd        r_wrd, n_wrd;
    t_wrd        r_w3;
    logic [63:0] r_out, n_out;
    logic [3:0]  r_cnt, n_cnt;
    logic [3:0]  adv;

    assign i_cfg.ready = 1'b1;
    assign adv[3] = !r_v[3] || o_out.ready;
    assign adv[2] = !r_v[2] || adv[3];
    assign adv[1] = !r_v[1] || adv[2];
    assign adv[0] = !r_v[0] || adv[1];
    assign i_in.ready = adv[0];

    fpcm_decode u_dec (.i_cfg(r_cfg), .i_bits(i_in.data), .o_dec(n_dec));
    fpcm_convert u_cnv (.i_dec(r_dec), .o_wrd(n_wrd));
    fpcm_pack u_pck (.i_wrd(r_w3), .o_bytes(n_out), .o_count(n_cnt));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{fmt: FMT_S16, big: 1'b0};
            r_v   <= 4'd0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == REG_FORMAT)
                    r_cfg.fmt <= t_fmt'(i_cfg.wdata[2:0]);
                else
                    r_cfg.big <= i_cfg.wdata[0];
            end
            if (adv[0]) r_v[0] <= i_in.valid;
            if (adv[1]) r_v[1] <= r_v[0];
            if (adv[2]) r_v[2] <= r_v[1];
            if (adv[3]) r_v[3] <= r_v[2];
        end
        if (adv[0]) r_dec <= n_dec;
        if (adv[1]) r_wrd <= n_wrd;
        if (adv[2]) r_w3  <= r_wrd;
        if (adv[3]) begin
            r_out <= n_out;
            r_cnt <= n_cnt;
        end
    end

    assign o_out.valid  = r_v[3];
    assign o_out.data   = r_out;
    assign o_byte_count = r_cnt;

    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready, o_out.valid && $stable(r_out))
    `ASSERT_IMPL(a_cnt, i_clk, i_rst_n, o_out.valid, r_cnt != 4'd0 && r_cnt <= 4'd8)
    `ASSERT_IMPL(a_stall, i_clk, i_rst_n, r_v == 4'hF && !o_out.ready, !i_in.ready)
endmodule
